/* src/swept_box_vs_box_collision_macros.svh */
// -----------------------------------------------------------------------------
// Swept box collision assertion macros
// Shared assertion forms for the collision block, clocked on i_clk and
// disabled while i_rst_n is low.
// -----------------------------------------------------------------------------
`ifndef SWEPT_BOX_VS_BOX_COLLISION_MACROS_SVH
`define SWEPT_BOX_VS_BOX_COLLISION_MACROS_SVH

// Same-cycle implication.
`define SBC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sbc assertion failed");

// Next-cycle implication.
`define SBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sbc assertion failed");

`endif

/* src/sbc_pkg.sv */
// -----------------------------------------------------------------------------
// Swept box collision package
// Shared types, register codes and arithmetic helpers.
// -----------------------------------------------------------------------------
package sbc_pkg;

    localparam int DIV_STAGES = 9;
    localparam int QDEPTH     = 2;

    localparam logic [1:0] REG_MOVER_W  = 2'd0;
    localparam logic [1:0] REG_MOVER_H  = 2'd1;
    localparam logic [1:0] REG_TARGET_W = 2'd2;
    localparam logic [1:0] REG_TARGET_H = 2'd3;

    typedef struct packed {
        logic [19:0] mover_w;
        logic [19:0] mover_h;
        logic [19:0] target_w;
        logic [19:0] target_h;
    } t_cfg;

    typedef struct packed {
        logic signed [23:0] old_x;
        logic signed [23:0] old_y;
        logic signed [23:0] new_x;
        logic signed [23:0] new_y;
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic signed [23:0] tgt_x;
        logic signed [23:0] tgt_y;
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic               ok_x;
        logic               ok_y;
        logic [23:0]        num_x;
        logic [23:0]        den_x;
        logic [23:0]        num_y;
        logic [23:0]        den_y;
    } t_job;

    // One restoring step: returns {quotient bit, new remainder}.
    function automatic logic [24:0] div_step(input logic [23:0] rem, input logic [23:0] den);
        logic [24:0] t;
        logic [24:0] d;
        t = {rem, 1'b0};
        d = {1'b0, den};
        if (t >= d) begin
            t = t - d;
            return {1'b1, t[23:0]};
        end
        return {1'b0, t[23:0]};
    endfunction

    // Signed divide by 256 with truncation toward zero.
    function automatic logic signed [26:0] tdiv256(input logic signed [34:0] v);
        logic signed [34:0] t;
        t = v + (v[34] ? 35'sd255 : 35'sd0);
        return t[34:8];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
        if (v > 28'sd8388607) begin
            return 24'sh7FFFFF;
        end
        if (v < -28'sd8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

    function automatic logic signed [23:0] neg_sat(input logic signed [23:0] v);
        if (v == 24'sh800000) begin
            return 24'sh7FFFFF;
        end
        return -v;
    endfunction

endpackage

/* src/sbc_cfg.sv */
// -----------------------------------------------------------------------------
// Swept box collision register file
// APB-style access to the four box size registers.
// -----------------------------------------------------------------------------
module sbc_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output sbc_pkg::t_cfg o_cfg
);
    import sbc_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mover_w  <= 20'd4096;
            r_cfg.mover_h  <= 20'd4096;
            r_cfg.target_w <= 20'd16384;
            r_cfg.target_h <= 20'd8192;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_MOVER_W:  r_cfg.mover_w  <= pwdata[19:0];
                REG_MOVER_H:  r_cfg.mover_h  <= pwdata[19:0];
                REG_TARGET_W: r_cfg.target_w <= pwdata[19:0];
                REG_TARGET_H: r_cfg.target_h <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MOVER_W:  prdata = {12'd0, r_cfg.mover_w};
            REG_MOVER_H:  prdata = {12'd0, r_cfg.mover_h};
            REG_TARGET_W: prdata = {12'd0, r_cfg.target_w};
            REG_TARGET_H: prdata = {12'd0, r_cfg.target_h};
            default:      prdata = 32'd0;
        endcase
    end
endmodule

/* src/sbc_front.sv */
// -----------------------------------------------------------------------------
// Swept box collision front end
// Accepts input transfers and classifies both axes for the divider.
// -----------------------------------------------------------------------------
module sbc_front (
    input  logic               i_valid,
    input  logic               i_full,
    input  logic signed [23:0] i_old_x,
    input  logic signed [23:0] i_old_y,
    input  logic signed [23:0] i_new_x,
    input  logic signed [23:0] i_new_y,
    input  logic signed [23:0] i_vel_x,
    input  logic signed [23:0] i_vel_y,
    input  logic signed [23:0] i_target_x,
    input  logic signed [23:0] i_target_y,
    input  sbc_pkg::t_cfg      i_cfg,
    output logic               o_stall,
    output logic               o_push,
    output sbc_pkg::t_job      o_job
);
    import sbc_pkg::*;

    logic signed [24:0] w_dx, w_dy;
    logic signed [26:0] w_plane_x, w_plane_y, w_num_x, w_num_y;
    logic        [26:0] w_nm_x, w_nm_y;
    logic        [24:0] w_dm_x, w_dm_y;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        w_dx = 25'(i_new_x) - 25'(i_old_x);
        w_dy = 25'(i_new_y) - 25'(i_old_y);
        w_plane_x = (i_vel_x > 24'sd0)
            ? 27'(i_target_x) - $signed({7'd0, i_cfg.mover_w})
            : 27'(i_target_x) + $signed({7'd0, i_cfg.target_w});
        w_plane_y = (i_vel_y > 24'sd0)
            ? 27'(i_target_y) - $signed({7'd0, i_cfg.mover_h})
            : 27'(i_target_y) + $signed({7'd0, i_cfg.target_h});
        w_num_x = w_plane_x - 27'(i_old_x);
        w_num_y = w_plane_y - 27'(i_old_y);
        w_nm_x  = w_num_x[26] ? 27'(-w_num_x) : 27'(w_num_x);
        w_nm_y  = w_num_y[26] ? 27'(-w_num_y) : 27'(w_num_y);
        w_dm_x  = w_dx[24] ? 25'(-w_dx) : 25'(w_dx);
        w_dm_y  = w_dy[24] ? 25'(-w_dy) : 25'(w_dy);

        o_job.old_x = i_old_x;
        o_job.old_y = i_old_y;
        o_job.new_x = i_new_x;
        o_job.new_y = i_new_y;
        o_job.vel_x = i_vel_x;
        o_job.vel_y = i_vel_y;
        o_job.tgt_x = i_target_x;
        o_job.tgt_y = i_target_y;
        o_job.dx    = w_dx;
        o_job.dy    = w_dy;
        // An axis takes part only when it moves, the entry plane lies ahead
        // and no farther than the full move.
        o_job.ok_x  = (w_dx != 25'sd0)
            && !(w_num_x != 27'sd0 && (w_num_x[26] != w_dx[24]))
            && (w_nm_x <= {2'd0, w_dm_x});
        o_job.ok_y  = (w_dy != 25'sd0)
            && !(w_num_y != 27'sd0 && (w_num_y[26] != w_dy[24]))
            && (w_nm_y <= {2'd0, w_dm_y});
        o_job.num_x = w_nm_x[23:0];
        o_job.den_x = w_dm_x[23:0];
        o_job.num_y = w_nm_y[23:0];
        o_job.den_y = w_dm_y[23:0];
    end
endmodule

/* src/sbc_queue.sv */
// -----------------------------------------------------------------------------
// Swept box collision job queue
// Two-entry queue between the front end and the back end.
// -----------------------------------------------------------------------------
`include "swept_box_vs_box_collision_macros.svh"

module sbc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sbc_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output sbc_pkg::t_job o_job
);
    import sbc_pkg::*;

    t_job       r_mem [QDEPTH];
    logic       r_wr, r_rd;
    logic [1:0] r_count;
    logic       w_push, w_pop;

    assign o_full  = (r_count == 2'(QDEPTH));
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(w_push) - 2'(w_pop);
        end
    end

    `SBC_ASSERT_IMP(a_count_bound, 1'b1, r_count <= 2'(QDEPTH))
    `SBC_ASSERT_NEXT(a_push_counts, w_push && !w_pop, !o_empty)
endmodule

/* src/sbc_back.sv */
// -----------------------------------------------------------------------------
// Swept box collision back end
// Pipelined entry-time divider, interpolation multipliers and hit resolve.
// -----------------------------------------------------------------------------
`include "swept_box_vs_box_collision_macros.svh"

module sbc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  sbc_pkg::t_job      i_job,
    output logic               o_pop,
    input  sbc_pkg::t_cfg      i_cfg,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_hit,
    output logic               o_hit_axis,
    output logic signed [23:0] o_out_x,
    output logic signed [23:0] o_out_y,
    output logic signed [23:0] o_out_vel_x,
    output logic signed [23:0] o_out_vel_y
);
    import sbc_pkg::*;

    logic        r_v  [DIV_STAGES];
    t_job        r_job[DIV_STAGES];
    logic [8:0]  r_qx [DIV_STAGES];
    logic [8:0]  r_qy [DIV_STAGES];
    logic [23:0] r_rx [DIV_STAGES];
    logic [23:0] r_ry [DIV_STAGES];
    logic [24:0] w_sx [DIV_STAGES];
    logic [24:0] w_sy [DIV_STAGES];

    logic               r_mv;
    t_job               r_mjob;
    logic [8:0]         r_mqx_ok;
    logic signed [34:0] r_pax, r_pox, r_pay, r_poy;

    logic               r_ov;
    logic               r_hit, r_axis;
    logic signed [23:0] r_x, r_y, r_vx, r_vy;

    logic               w_adv, w_q0x, w_q0y;
    logic signed [27:0] w_px, w_py, w_cx, w_cy;
    logic               w_hx, w_hy;

    // The whole pipeline moves while the output register can take a result.
    assign w_adv = !r_ov || !i_stall;
    assign o_pop = w_adv && !i_empty;
    assign w_q0x = i_job.num_x >= i_job.den_x;
    assign w_q0y = i_job.num_y >= i_job.den_y;

    always_comb begin
        w_sx[0] = '0;
        w_sy[0] = '0;
        for (int s = 1; s < DIV_STAGES; s++) begin
            w_sx[s] = div_step(r_rx[s-1], r_job[s-1].den_x);
            w_sy[s] = div_step(r_ry[s-1], r_job[s-1].den_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_job[0] <= i_job;
            r_qx[0]  <= {8'd0, w_q0x};
            r_qy[0]  <= {8'd0, w_q0y};
            r_rx[0]  <= w_q0x ? i_job.num_x - i_job.den_x : i_job.num_x;
            r_ry[0]  <= w_q0y ? i_job.num_y - i_job.den_y : i_job.num_y;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_job[s] <= r_job[s-1];
                r_qx[s]  <= {r_qx[s-1][7:0], w_sx[s][24]};
                r_qy[s]  <= {r_qy[s-1][7:0], w_sy[s][24]};
                r_rx[s]  <= w_sx[s][23:0];
                r_ry[s]  <= w_sy[s][23:0];
            end
            r_mjob   <= r_job[DIV_STAGES-1];
            r_mqx_ok <= r_qx[DIV_STAGES-1];
            r_pax <= $signed({1'b0, r_qx[DIV_STAGES-1]}) * r_job[DIV_STAGES-1].dx;
            r_pox <= $signed({1'b0, r_qx[DIV_STAGES-1]}) * r_job[DIV_STAGES-1].dy;
            r_pay <= $signed({1'b0, r_qy[DIV_STAGES-1]}) * r_job[DIV_STAGES-1].dy;
            r_poy <= $signed({1'b0, r_qy[DIV_STAGES-1]}) * r_job[DIV_STAGES-1].dx;
            r_hit  <= w_hx || w_hy;
            r_axis <= !w_hx && w_hy;
            r_x    <= w_hx ? sat24(w_cx) : r_mjob.new_x;
            r_y    <= (!w_hx && w_hy) ? sat24(w_cy) : r_mjob.new_y;
            r_vx   <= w_hx ? neg_sat(r_mjob.vel_x) : r_mjob.vel_x;
            r_vy   <= (!w_hx && w_hy) ? neg_sat(r_mjob.vel_y) : r_mjob.vel_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_v[s] <= 1'b0;
            end
            r_mv <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_v[0] <= !i_empty;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_v[s] <= r_v[s-1];
            end
            r_mv <= r_v[DIV_STAGES-1];
            r_ov <= r_mv;
        end
    end

    always_comb begin
        // Other coordinate at the entry time, then strict overlap on both sides.
        w_py = 28'(r_mjob.old_y) + 28'(tdiv256(r_pox));
        w_px = 28'(r_mjob.old_x) + 28'(tdiv256(r_poy));
        w_cx = 28'(r_mjob.old_x) + 28'(tdiv256(r_pax));
        w_cy = 28'(r_mjob.old_y) + 28'(tdiv256(r_pay));
        w_hx = r_mjob.ok_x
            && (w_py + $signed({8'd0, i_cfg.mover_h}) > 28'(r_mjob.tgt_y))
            && (w_py < 28'(r_mjob.tgt_y) + $signed({8'd0, i_cfg.target_h}));
        w_hy = r_mjob.ok_y
            && (w_px + $signed({8'd0, i_cfg.mover_w}) > 28'(r_mjob.tgt_x))
            && (w_px < 28'(r_mjob.tgt_x) + $signed({8'd0, i_cfg.target_w}));
    end

    assign o_valid     = r_ov;
    assign o_hit       = r_hit;
    assign o_hit_axis  = r_axis;
    assign o_out_x     = r_x;
    assign o_out_y     = r_y;
    assign o_out_vel_x = r_vx;
    assign o_out_vel_y = r_vy;

    `SBC_ASSERT_IMP(a_axis_needs_hit, r_ov && r_axis, r_hit)
    `SBC_ASSERT_NEXT(a_stage_moves, w_adv && r_v[0], r_v[1])
    `SBC_ASSERT_IMP(a_tq_range, r_mv && r_mjob.ok_x && r_mqx_ok[8], r_mqx_ok[7:0] == 8'd0)
endmodule

/* src/swept_box_vs_box_collision.sv */
// -----------------------------------------------------------------------------
// Swept box versus box collision
// Throughput: one transfer per cycle while the output is not stalled; the
// entry-time divider retires one quotient bit per stage over nine stages,
// so it is fully pipelined.
// Reset (synchronous, i_rst_n low) empties the queue and pipeline and loads the
// register reset sizes; no clearing pass is needed.
// -----------------------------------------------------------------------------
module swept_box_vs_box_collision (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [23:0] i_old_x,
    input  logic signed [23:0] i_old_y,
    input  logic signed [23:0] i_new_x,
    input  logic signed [23:0] i_new_y,
    input  logic signed [23:0] i_vel_x,
    input  logic signed [23:0] i_vel_y,
    input  logic signed [23:0] i_target_x,
    input  logic signed [23:0] i_target_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_hit,
    output logic               o_hit_axis,
    output logic signed [23:0] o_out_x,
    output logic signed [23:0] o_out_y,
    output logic signed [23:0] o_out_vel_x,
    output logic signed [23:0] o_out_vel_y,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import sbc_pkg::*;

    // The front end classifies each transfer: per axis it forms the motion,
    // picks the entry plane from the velocity sign and decides whether the
    // entry time falls within the move. Jobs then wait in a two-entry queue,
    // so the input side can take up to two transfers while the back end is held.
    // The back end divides the entry-plane distance by the motion to get the
    // entry time, interpolates the other axis, tests overlap and resolves the
    // x axis ahead of the y axis.

    t_cfg w_cfg;
    t_job w_front_job, w_back_job;
    logic w_push, w_pop, w_full, w_empty;

    sbc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sbc_front u_front (
        .i_valid    (i_valid),
        .i_full     (w_full),
        .i_old_x    (i_old_x),
        .i_old_y    (i_old_y),
        .i_new_x    (i_new_x),
        .i_new_y    (i_new_y),
        .i_vel_x    (i_vel_x),
        .i_vel_y    (i_vel_y),
        .i_target_x (i_target_x),
        .i_target_y (i_target_y),
        .i_cfg      (w_cfg),
        .o_stall    (o_stall),
        .o_push     (w_push),
        .o_job      (w_front_job)
    );

    sbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_job   (w_back_job)
    );

    sbc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_job       (w_back_job),
        .o_pop       (w_pop),
        .i_cfg       (w_cfg),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_hit       (o_hit),
        .o_hit_axis  (o_hit_axis),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_vel_x (o_out_vel_x),
        .o_out_vel_y (o_out_vel_y)
    );
endmodule
